@@ src/assert_macros.svh @@
// Concurrent check helpers; expect clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

@@ src/lzwc_pkg.sv @@
package lzwc_pkg;

	localparam int CODE_BITS  = 12;
	localparam int ALPHA_SIZE = 32;
	localparam int SYM_W      = 5;
	localparam int CODE_W     = 12;
	localparam int NCODE_W    = CODE_BITS + 1;
	localparam int DICT_SIZE  = 1 << CODE_BITS;
	localparam int TAB_BITS   = CODE_BITS + 1;
	localparam int TAB_SIZE   = 1 << TAB_BITS;
	localparam int EPOCH_BITS = 8;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} in_word_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last_res;
	} out_word_t;

	typedef struct packed {
		logic [EPOCH_BITS-1:0] epoch;
		logic [CODE_BITS-1:0]  key_prefix;
		logic [SYM_W-1:0]      key_sym;
		logic [CODE_BITS-1:0]  code;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_MATCH,
		ST_EMIT_OLD,
		ST_EMIT_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic advance;
		logic set_first;
		logic take_hit;
		logic miss;
		logic push;
		logic push_fin;
		logic end_block;
		logic clr_wr;
	} cmd_t;

	typedef struct packed {
		logic prefix_valid;
		logic last;
		logic hit;
		logic empty;
		logic out_free;
		logic clr_last;
	} status_t;

	function automatic logic [SYM_W-1:0] sat_sym(input logic [SYM_W-1:0] s);
		if (int'(s) >= ALPHA_SIZE) begin
			return SYM_W'(ALPHA_SIZE - 1);
		end
		return s;
	endfunction

	function automatic logic [TAB_BITS-1:0] hash_idx(input logic [CODE_BITS-1:0] p,
			input logic [SYM_W-1:0] s);
		return TAB_BITS'(p) ^ (TAB_BITS'(s) << (TAB_BITS - SYM_W));
	endfunction

endpackage

@@ src/lzw_compressor_5bit_alphabet_unit.sv @@
// LZW compressor, 32-symbol alphabet, 12-bit codes.
// Source channel (src_valid/src_stall/src_data): one symbol word per item, with
// a last flag on the final symbol of a data block. Result channel
// (res_valid/res_stall/res_data): code words; last_res marks a block's final code.
// An item produces zero, one or two codes; every block starts a fresh dictionary.
// Items are taken one at a time. A lookup issues a hash table read (PROBE), then
// compares the registered entry (MATCH); a collision repeats both at the next
// slot of the single-port hash table. A miss then emits and inserts (EMIT_OLD);
// the last item also emits the final code (EMIT_FIN). A block's first symbol
// only seeds the prefix. The output register lets the next symbol be taken while
// a code waits; an item that must emit while res_stall holds waits in place until
// the word moves on. After reset, and once every 255 blocks when the epoch tag
// wraps, the table is swept clear, all 8192 slots, with src_stall high.
module lzw_compressor_5bit_alphabet_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  lzwc_pkg::in_word_t  src_data,
	output logic                res_valid,
	input  logic                res_stall,
	output lzwc_pkg::out_word_t res_data
);

	lzwc_pkg::cmd_t    cmd;
	lzwc_pkg::status_t sts;

	lzwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lzwc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_data  (src_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

@@ src/lzwc_ctrl.sv @@
module lzwc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  lzwc_pkg::status_t sts,
	output lzwc_pkg::cmd_t    cmd
);

	lzwc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzwc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lzwc_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = lzwc_pkg::ST_IDLE;
			end
			lzwc_pkg::ST_IDLE: begin
				if (src_valid) state_d = lzwc_pkg::ST_PROBE;
			end
			lzwc_pkg::ST_PROBE: begin
				if (!sts.prefix_valid) begin
					state_d = sts.last ? lzwc_pkg::ST_EMIT_FIN : lzwc_pkg::ST_IDLE;
				end else begin
					state_d = lzwc_pkg::ST_MATCH;
				end
			end
			lzwc_pkg::ST_MATCH: begin
				if (sts.hit) begin
					state_d = sts.last ? lzwc_pkg::ST_EMIT_FIN : lzwc_pkg::ST_IDLE;
				end else if (sts.empty) begin
					state_d = lzwc_pkg::ST_EMIT_OLD;
				end else begin
					state_d = lzwc_pkg::ST_PROBE;
				end
			end
			lzwc_pkg::ST_EMIT_OLD: begin
				if (sts.out_free) begin
					state_d = sts.last ? lzwc_pkg::ST_EMIT_FIN : lzwc_pkg::ST_IDLE;
				end
			end
			lzwc_pkg::ST_EMIT_FIN: begin
				// epoch about to wrap: wipe the table before the next block
				if (sts.out_free) begin
					state_d = sts.clr_last ? lzwc_pkg::ST_CLEAR : lzwc_pkg::ST_IDLE;
				end
			end
			default: state_d = lzwc_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		src_stall = 1'b1;
		case (state_q)
			lzwc_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			lzwc_pkg::ST_IDLE: begin
				src_stall = 1'b0;
				cmd.load  = src_valid;
			end
			lzwc_pkg::ST_PROBE: begin
				cmd.set_first = !sts.prefix_valid;
				cmd.rd        = sts.prefix_valid;
			end
			lzwc_pkg::ST_MATCH: begin
				cmd.take_hit = sts.hit;
				cmd.advance  = !sts.hit && !sts.empty;
			end
			lzwc_pkg::ST_EMIT_OLD: begin
				cmd.push = sts.out_free;
				cmd.miss = sts.out_free;
			end
			lzwc_pkg::ST_EMIT_FIN: begin
				cmd.push      = sts.out_free;
				cmd.push_fin  = sts.out_free;
				cmd.end_block = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ src/lzwc_dpath.sv @@
module lzwc_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  lzwc_pkg::in_word_t  src_data,
	input  lzwc_pkg::cmd_t      cmd,
	output lzwc_pkg::status_t   sts,
	output logic                res_valid,
	input  logic                res_stall,
	output lzwc_pkg::out_word_t res_data
);

	logic [lzwc_pkg::SYM_W-1:0]      sym_q;
	logic                            last_q;
	logic [lzwc_pkg::CODE_BITS-1:0]  prefix_q;
	logic                            pv_q;
	logic [lzwc_pkg::NCODE_W-1:0]    next_code_q;
	logic [lzwc_pkg::EPOCH_BITS-1:0] epoch_q;
	logic [lzwc_pkg::TAB_BITS-1:0]   idx_q;
	logic [lzwc_pkg::TAB_BITS-1:0]   clr_idx_q;
	lzwc_pkg::entry_t                rdata_q;
	logic                            res_valid_q;
	lzwc_pkg::out_word_t             res_data_q;

	lzwc_pkg::entry_t mem [lzwc_pkg::TAB_SIZE];

	logic [lzwc_pkg::SYM_W-1:0]    in_sym;
	logic                          full;
	logic                          epoch_max;
	logic                          clr_end;
	logic                          we;
	logic [lzwc_pkg::TAB_BITS-1:0] waddr;
	lzwc_pkg::entry_t              wdata;
	logic                          out_free;

	assign in_sym    = lzwc_pkg::sat_sym(src_data.symbol);
	assign full      = (next_code_q >= lzwc_pkg::NCODE_W'(lzwc_pkg::DICT_SIZE));
	assign epoch_max = &epoch_q;
	assign clr_end   = &clr_idx_q;
	assign out_free  = !res_valid_q || !res_stall;

	assign sts.prefix_valid = pv_q;
	assign sts.last         = last_q;
	// slot from an older epoch counts as empty
	assign sts.empty    = (rdata_q.epoch != epoch_q);
	assign sts.hit      = (rdata_q.epoch == epoch_q) && (rdata_q.key_prefix == prefix_q)
		&& (rdata_q.key_sym == sym_q);
	assign sts.out_free = out_free;
	assign sts.clr_last = cmd.clr_wr ? clr_end : epoch_max;

	// single port: either the clear sweep or a miss insert writes
	always_comb begin
		we    = cmd.clr_wr || (cmd.miss && !full);
		waddr = cmd.clr_wr ? clr_idx_q : idx_q;
		if (cmd.clr_wr) begin
			wdata = '0;
		end else begin
			wdata.epoch      = epoch_q;
			wdata.key_prefix = prefix_q;
			wdata.key_sym    = sym_q;
			wdata.code       = lzwc_pkg::CODE_BITS'(next_code_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q  <= in_sym;
			last_q <= src_data.last;
			idx_q  <= lzwc_pkg::hash_idx(prefix_q, in_sym);
		end else if (cmd.advance) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q    <= '0;
			pv_q        <= 1'b0;
			next_code_q <= lzwc_pkg::NCODE_W'(lzwc_pkg::ALPHA_SIZE);
			epoch_q     <= lzwc_pkg::EPOCH_BITS'(1);
			clr_idx_q   <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_end) epoch_q <= lzwc_pkg::EPOCH_BITS'(1);
			end
			if (cmd.set_first) begin
				prefix_q <= lzwc_pkg::CODE_BITS'(sym_q);
				pv_q     <= 1'b1;
			end
			if (cmd.take_hit) begin
				prefix_q <= rdata_q.code;
			end
			if (cmd.miss) begin
				prefix_q <= lzwc_pkg::CODE_BITS'(sym_q);
				if (!full) next_code_q <= next_code_q + 1'b1;
			end
			if (cmd.end_block) begin
				pv_q        <= 1'b0;
				prefix_q    <= '0;
				next_code_q <= lzwc_pkg::NCODE_W'(lzwc_pkg::ALPHA_SIZE);
				if (!epoch_max) epoch_q <= epoch_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.push) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			res_data_q.code     <= lzwc_pkg::CODE_W'(prefix_q);
			res_data_q.last_res <= cmd.push_fin;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

@@ src/lzwc_checker.sv @@
`include "assert_macros.svh"

module lzwc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                src_valid,
	input logic                src_stall,
	input lzwc_pkg::in_word_t  src_data,
	input logic                res_valid,
	input logic                res_stall,
	input lzwc_pkg::out_word_t res_data
);

	// one symbol in flight: a taken word closes the source side next cycle
	`CHK_NEXT(a_one_item, src_valid && !src_stall, src_stall)

	// codes are only produced while a symbol is being worked on
	`CHK_NOW(a_code_from_work, $rose(res_valid), $past(src_stall))

	// a code word waiting on the receiver holds
	`CHK_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data))

	// a presented code word carries no unknown bits
	`CHK_NOW(a_res_known, res_valid, !$isunknown(res_data))

endmodule

bind lzw_compressor_5bit_alphabet_unit lzwc_checker u_lzwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.src_data  (src_data),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);
